/* src/bmf_pkg.sv */
// Shared types and constants for the cache bus master.
// Used by bmf_in_stage, bmf_step and icache_dcache_bus_master_fsm.
package bmf_pkg;

  localparam int unsigned AddrWidth = 32;
  localparam int unsigned DataWidth = 32;
  localparam int unsigned SelWidth  = 4;
  localparam int unsigned StWidth   = 3;

  // bus master state codes
  localparam logic [StWidth-1:0] StIdle     = 3'd0;
  localparam logic [StWidth-1:0] StReq      = 3'd1;
  localparam logic [StWidth-1:0] StDrd      = 3'd2;
  localparam logic [StWidth-1:0] StDrdEnd   = 3'd3;
  localparam logic [StWidth-1:0] StDwr      = 3'd4;
  localparam logic [StWidth-1:0] StFetch    = 3'd5;
  localparam logic [StWidth-1:0] StFetchEnd = 3'd6;

  // sampled cache and bus signals of one request
  typedef struct packed {
    logic                 dcache_valid;
    logic                 dcache_read;
    logic                 dcache_write;
    logic [AddrWidth-1:0] dcache_addr;
    logic [DataWidth-1:0] dcache_wdata;
    logic [SelWidth-1:0]  dcache_byte_sel;
    logic                 icache_valid;
    logic [AddrWidth-1:0] icache_addr;
    logic                 bus_grant;
    logic                 bus_ack;
    logic [DataWidth-1:0] bus_rdata;
  } item_t;

  // driven bus and cache outputs of one step
  typedef struct packed {
    logic                 bus_cycle;
    logic                 bus_strobe;
    logic [AddrWidth-1:0] bus_addr;
    logic [SelWidth-1:0]  bus_byte_sel;
    logic                 bus_write_enable;
    logic [DataWidth-1:0] bus_wdata;
    logic                 dcache_ack;
    logic [DataWidth-1:0] dcache_rdata;
    logic                 icache_ack;
    logic [DataWidth-1:0] icache_rdata;
    logic                 core_stall;
  } result_t;

endpackage

/* src/bmf_in_stage.sv */
// Input register stage: holds one sampled request until the step logic takes it.
// Depends on bmf_pkg for item_t.
module bmf_in_stage import bmf_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  item_t item_i,
  output logic  valid_o,
  input  logic  ready_i,
  output item_t item_o
);

  logic  valid_q, valid_d;
  item_t item_q;

  // stage is free when empty or draining this cycle
  assign ready_o = !valid_q || ready_i;
  assign valid_d = (valid_i && ready_o) || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload capture
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

/* src/bmf_step.sv */
// Next-state and output logic of the bus master for one step.
// Depends on bmf_pkg for state codes, item_t and result_t.
module bmf_step import bmf_pkg::*; (
  input  logic [StWidth-1:0] state_i,
  input  item_t              item_i,
  input  result_t            held_i,
  output logic [StWidth-1:0] state_o,
  output result_t            result_o
);

  always_comb begin
    // held fields keep their values unless a state drives them
    result_o            = held_i;
    result_o.bus_cycle  = 1'b0;
    result_o.bus_strobe = 1'b0;
    result_o.dcache_ack = 1'b0;
    result_o.icache_ack = 1'b0;
    state_o             = StIdle;

    case (state_i)
      StReq: begin
        result_o.bus_cycle = 1'b1;
        if (item_i.bus_grant && item_i.dcache_valid && item_i.dcache_read) begin
          state_o = StDrd;
        end else if (item_i.bus_grant && item_i.dcache_valid && item_i.dcache_write) begin
          state_o = StDwr;
        end else if (item_i.bus_grant && item_i.icache_valid && !item_i.dcache_valid) begin
          state_o = StFetch;
        end else begin
          state_o = StReq;
        end
      end
      StDrd: begin
        result_o.bus_cycle        = 1'b1;
        result_o.bus_strobe       = 1'b1;
        result_o.bus_addr         = item_i.dcache_addr;
        result_o.bus_byte_sel     = item_i.dcache_byte_sel;
        result_o.bus_write_enable = 1'b0;
        result_o.dcache_ack       = item_i.bus_ack;
        result_o.dcache_rdata     = item_i.bus_rdata;
        state_o = item_i.bus_ack ? StDrdEnd : StDrd;
      end
      StDrdEnd: begin
        result_o.bus_cycle    = 1'b1;
        result_o.dcache_ack   = item_i.bus_ack;
        result_o.dcache_rdata = item_i.bus_rdata;
        if (item_i.bus_ack) begin
          state_o = StDrdEnd;
        end else begin
          state_o = item_i.icache_valid ? StFetch : StIdle;
        end
      end
      StDwr: begin
        result_o.bus_cycle        = 1'b1;
        result_o.bus_strobe       = 1'b1;
        result_o.bus_wdata        = item_i.dcache_wdata;
        result_o.bus_addr         = item_i.dcache_addr;
        result_o.bus_byte_sel     = item_i.dcache_byte_sel;
        result_o.bus_write_enable = 1'b1;
        result_o.dcache_ack       = item_i.bus_ack;
        if (item_i.bus_ack) begin
          state_o = item_i.icache_valid ? StFetch : StIdle;
        end else begin
          state_o = StDwr;
        end
      end
      StFetch: begin
        result_o.bus_cycle        = 1'b1;
        result_o.bus_strobe       = 1'b1;
        result_o.bus_addr         = item_i.icache_addr;
        result_o.bus_byte_sel     = '0;
        result_o.bus_write_enable = 1'b0;
        result_o.icache_rdata     = item_i.bus_rdata;
        result_o.icache_ack       = item_i.bus_ack;
        state_o = item_i.bus_ack ? StFetchEnd : StFetch;
      end
      StFetchEnd: begin
        result_o.bus_cycle    = 1'b1;
        result_o.icache_rdata = item_i.bus_rdata;
        result_o.icache_ack   = item_i.bus_ack;
        state_o = item_i.bus_ack ? StFetchEnd : StIdle;
      end
      default: begin
        // idle, and the unused code behaves as idle
        state_o = (item_i.dcache_valid || item_i.icache_valid) ? StReq : StIdle;
      end
    endcase

    result_o.core_stall = result_o.bus_cycle;
  end

endmodule

/* src/icache_dcache_bus_master_fsm.sv */
// Top level of the cache bus master: input stage, step logic, state and result register.
// Depends on bmf_pkg, bmf_in_stage and bmf_step.
//
//  channel | handshake              | payload
//  --------+------------------------+---------------------------------------------
//  in      | in_valid_i / in_ready_o | dcache_*_i, icache_*_i, bus_grant/ack/rdata_i
//  out     | out_valid_o/out_ready_i | bus_*_o, dcache_ack/rdata_o, icache_*_o, core_stall_o
//
// One request per cycle is sustained while the output is not stalled; a request passes
// through the input register, then the state step into the result register, to the output.
// Reset puts the machine in idle and clears every held output field to zero.
// A stalled output holds its result; the input register keeps taking a request while
// it drains, so the input side stops only when both registers are full.
module icache_dcache_bus_master_fsm import bmf_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 dcache_valid_i,
  input  logic                 dcache_read_i,
  input  logic                 dcache_write_i,
  input  logic [AddrWidth-1:0] dcache_addr_i,
  input  logic [DataWidth-1:0] dcache_wdata_i,
  input  logic [SelWidth-1:0]  dcache_byte_sel_i,
  input  logic                 icache_valid_i,
  input  logic [AddrWidth-1:0] icache_addr_i,
  input  logic                 bus_grant_i,
  input  logic                 bus_ack_i,
  input  logic [DataWidth-1:0] bus_rdata_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 bus_cycle_o,
  output logic                 bus_strobe_o,
  output logic [AddrWidth-1:0] bus_addr_o,
  output logic [SelWidth-1:0]  bus_byte_sel_o,
  output logic                 bus_write_enable_o,
  output logic [DataWidth-1:0] bus_wdata_o,
  output logic                 dcache_ack_o,
  output logic [DataWidth-1:0] dcache_rdata_o,
  output logic                 icache_ack_o,
  output logic [DataWidth-1:0] icache_rdata_o,
  output logic                 core_stall_o
);

  item_t              in_item;
  item_t              st_item;
  logic               st_valid;
  logic               st_take;
  logic [StWidth-1:0] state_q, state_d;
  result_t            result_q, result_d;
  logic               out_valid_q, out_valid_d;

  // gather the request fields
  always_comb begin
    in_item.dcache_valid    = dcache_valid_i;
    in_item.dcache_read     = dcache_read_i;
    in_item.dcache_write    = dcache_write_i;
    in_item.dcache_addr     = dcache_addr_i;
    in_item.dcache_wdata    = dcache_wdata_i;
    in_item.dcache_byte_sel = dcache_byte_sel_i;
    in_item.icache_valid    = icache_valid_i;
    in_item.icache_addr     = icache_addr_i;
    in_item.bus_grant       = bus_grant_i;
    in_item.bus_ack         = bus_ack_i;
    in_item.bus_rdata       = bus_rdata_i;
  end

  bmf_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .item_i  (in_item),
    .valid_o (st_valid),
    .ready_i (st_take),
    .item_o  (st_item)
  );

  // the result register also serves as the held bus and cache fields
  bmf_step u_step (
    .state_i  (state_q),
    .item_i   (st_item),
    .held_i   (result_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  // step when the result register is empty or being taken
  assign st_take     = !out_valid_q || out_ready_i;
  assign out_valid_d = (st_valid && st_take) || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      result_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (st_valid && st_take) begin
        state_q  <= state_d;
        result_q <= result_d;
      end
    end
  end

  // output ports
  assign out_valid_o        = out_valid_q;
  assign bus_cycle_o        = result_q.bus_cycle;
  assign bus_strobe_o       = result_q.bus_strobe;
  assign bus_addr_o         = result_q.bus_addr;
  assign bus_byte_sel_o     = result_q.bus_byte_sel;
  assign bus_write_enable_o = result_q.bus_write_enable;
  assign bus_wdata_o        = result_q.bus_wdata;
  assign dcache_ack_o       = result_q.dcache_ack;
  assign dcache_rdata_o     = result_q.dcache_rdata;
  assign icache_ack_o       = result_q.icache_ack;
  assign icache_rdata_o     = result_q.icache_rdata;
  assign core_stall_o       = result_q.core_stall;

endmodule
